@@ rtl/core/cvfd_pkg.sv @@
// ----------------------------------------------------------------------------
// cvfd_pkg
// Shared types, constants and the crc-8 helpers of the cell voltage frame
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cvfd_pkg;

    localparam logic [7:0] CRC_INIT       = 8'h41;
    localparam logic [4:0] FRAME_LEN_LONG  = 5'd19;
    localparam logic [4:0] FRAME_LEN_SHORT = 5'd16;
    localparam logic [4:0] LONG_FRAME_MIN_CELLS = 5'd10;
    localparam logic [3:0] CELLS_RESET    = 4'd12;
    localparam logic [11:0] CODE_OFFSET   = 12'd512;

    localparam logic CFG_CELLS_LOWER = 1'b0;
    localparam logic CFG_CELLS_UPPER = 1'b1;

    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_MID  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    typedef struct packed {
        logic        kind;
        logic        device_sel;
        logic        last;
        logic [4:0]  cell_index;
        logic [11:0] code;
        logic [7:0]  check_byte;
        logic [7:0]  crc;
    } t_work;

    typedef struct packed {
        logic               kind;
        logic               device_sel;
        logic [4:0]         cell_index;
        logic signed [13:0] voltage_mv;
        logic               check_ok;
        logic               last;
    } t_result;

    function automatic logic [7:0] crc_nib(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'h0: v = 8'h00;
            4'h1: v = 8'h07;
            4'h2: v = 8'h0E;
            4'h3: v = 8'h09;
            4'h4: v = 8'h1C;
            4'h5: v = 8'h1B;
            4'h6: v = 8'h12;
            4'h7: v = 8'h15;
            4'h8: v = 8'h38;
            4'h9: v = 8'h3F;
            4'hA: v = 8'h36;
            4'hB: v = 8'h31;
            4'hC: v = 8'h24;
            4'hD: v = 8'h23;
            4'hE: v = 8'h2A;
            4'hF: v = 8'h2D;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = {crc[3:0], 4'h0} ^ crc_nib(crc[7:4] ^ b[7:4]);
        return {c[3:0], 4'h0} ^ crc_nib(c[7:4] ^ b[3:0]);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/cvfd_fifo.sv @@
// ----------------------------------------------------------------------------
// cvfd_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
`default_nettype none

module cvfd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_full,
    input  wire logic             i_rd_en,
    output logic [WIDTH-1:0]      o_rd_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_go;
    logic             rd_go;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_go     = i_wr_en && !o_full;
    assign rd_go     = i_rd_en && !o_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_go) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (rd_go) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (wr_go && !rd_go) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_go && !wr_go) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cvfd_front.sv @@
// ----------------------------------------------------------------------------
// cvfd_front
// Byte intake: frame position, crc-8, code unpack and result classification.
// ----------------------------------------------------------------------------
`default_nettype none

module cvfd_front #(
    parameter int MAX_CELLS_PER_DEVICE = 12
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_index,
    input  wire logic [3:0]     i_cfg_data,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_rx_byte,
    input  wire logic           i_frame_start,
    output logic                o_work_valid,
    output cvfd_pkg::t_work     o_work
);

    localparam logic [3:0] MAX_CELLS = 4'(MAX_CELLS_PER_DEVICE);

    logic [3:0]  r_cells_lower;
    logic [3:0]  r_cells_upper;
    logic [7:0]  r_crc,   n_crc;
    logic [4:0]  r_pos,   n_pos;
    logic [1:0]  r_phase, n_phase;
    logic        r_sel,   n_sel;
    logic [11:0] r_part,  n_part;
    logic [3:0]  r_done,  n_done;

    logic [7:0]  crc_c;
    logic [4:0]  pos_c;
    logic [1:0]  phase_c;
    logic        sel_c;
    logic [11:0] part_c;
    logic [3:0]  done_c;
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [3:0]  count;
    logic [3:0]  base;
    logic [4:0]  frame_len;
    logic [11:0] code;
    logic        have;

    assign lo        = (r_cells_lower > MAX_CELLS) ? MAX_CELLS : r_cells_lower;
    assign hi        = (r_cells_upper > MAX_CELLS) ? MAX_CELLS : r_cells_upper;
    assign frame_len = (({1'b0, lo} + {1'b0, hi}) > cvfd_pkg::LONG_FRAME_MIN_CELLS)
                       ? cvfd_pkg::FRAME_LEN_LONG : cvfd_pkg::FRAME_LEN_SHORT;
    // count and base follow the device of the previous byte, before a restart
    assign count     = r_sel ? hi : lo;
    assign base      = r_sel ? lo : 4'd0;

    assign crc_c   = i_frame_start ? cvfd_pkg::CRC_INIT : r_crc;
    assign pos_c   = i_frame_start ? 5'd0 : r_pos;
    assign phase_c = i_frame_start ? cvfd_pkg::PH_LOW : r_phase;
    assign sel_c   = i_frame_start ? 1'b0 : r_sel;
    assign part_c  = i_frame_start ? 12'd0 : r_part;
    assign done_c  = i_frame_start ? 4'd0 : r_done;

    always_comb begin
        n_crc        = r_crc;
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_sel        = r_sel;
        n_part       = r_part;
        n_done       = r_done;
        code         = 12'd0;
        have         = 1'b0;
        o_work_valid = 1'b0;
        o_work       = '0;
        if (i_accept) begin
            if (pos_c >= frame_len - 5'd1) begin
                o_work_valid      = 1'b1;
                o_work.kind       = cvfd_pkg::KIND_CHECK;
                o_work.device_sel = sel_c;
                o_work.last       = sel_c;
                o_work.check_byte = i_rx_byte;
                o_work.crc        = crc_c;
                n_crc   = cvfd_pkg::CRC_INIT;
                n_pos   = 5'd0;
                n_phase = cvfd_pkg::PH_LOW;
                n_part  = 12'd0;
                n_done  = 4'd0;
                n_sel   = ~sel_c;
            end else begin
                n_crc   = cvfd_pkg::crc_byte(crc_c, i_rx_byte);
                n_pos   = pos_c + 5'd1;
                n_sel   = sel_c;
                n_done  = done_c;
                unique case (phase_c)
                    cvfd_pkg::PH_LOW: begin
                        n_part  = {4'h0, i_rx_byte};
                        n_phase = cvfd_pkg::PH_MID;
                    end
                    cvfd_pkg::PH_MID: begin
                        code    = {i_rx_byte[3:0], part_c[7:0]};
                        n_part  = {8'h00, i_rx_byte[7:4]};
                        have    = 1'b1;
                        n_phase = cvfd_pkg::PH_HIGH;
                    end
                    default: begin
                        code    = {i_rx_byte, part_c[3:0]};
                        n_part  = 12'd0;
                        have    = 1'b1;
                        n_phase = cvfd_pkg::PH_LOW;
                    end
                endcase
                if (have && (done_c < count)) begin
                    o_work_valid      = 1'b1;
                    o_work.kind       = cvfd_pkg::KIND_CELL;
                    o_work.device_sel = sel_c;
                    o_work.cell_index = {1'b0, base} + {1'b0, done_c};
                    o_work.code       = code;
                    n_done            = done_c + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= cvfd_pkg::CRC_INIT;
            r_pos   <= 5'd0;
            r_phase <= cvfd_pkg::PH_LOW;
            r_sel   <= 1'b0;
            r_part  <= 12'd0;
            r_done  <= 4'd0;
        end else begin
            r_crc   <= n_crc;
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_sel   <= n_sel;
            r_part  <= n_part;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_lower <= cvfd_pkg::CELLS_RESET;
            r_cells_upper <= cvfd_pkg::CELLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cvfd_pkg::CFG_CELLS_LOWER: r_cells_lower <= i_cfg_data;
                cvfd_pkg::CFG_CELLS_UPPER: r_cells_upper <= i_cfg_data;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cvfd_back.sv @@
// ----------------------------------------------------------------------------
// cvfd_back
// Result stage: code to millivolt scaling and check byte compare.
// ----------------------------------------------------------------------------
`default_nettype none

module cvfd_back (
    input  wire logic            i_work_avail,
    input  wire cvfd_pkg::t_work i_work,
    input  wire logic            i_res_full,
    output logic                 o_work_take,
    output logic                 o_res_push,
    output cvfd_pkg::t_result    o_res
);

    logic [14:0] diff;
    logic [14:0] scaled;

    // (code - 512) * 3, then arithmetic shift right by one
    assign diff   = {3'b000, i_work.code} - {3'b000, cvfd_pkg::CODE_OFFSET};
    assign scaled = diff + {diff[13:0], 1'b0};

    assign o_work_take = i_work_avail && !i_res_full;
    assign o_res_push  = o_work_take;

    always_comb begin
        o_res            = '0;
        o_res.kind       = i_work.kind;
        o_res.device_sel = i_work.device_sel;
        if (i_work.kind == cvfd_pkg::KIND_CHECK) begin
            o_res.check_ok = (i_work.check_byte == i_work.crc);
            o_res.last     = i_work.last;
        end else begin
            o_res.cell_index = i_work.cell_index;
            o_res.voltage_mv = $signed(scaled[14:1]);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cell_voltage_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// cell_voltage_frame_decoder
// Unpacks 12-bit cell codes of two stacked monitor frames and checks crc-8.
//
// Input queue side: one readback byte per transfer (push while full is low),
// with i_frame_start marking the first byte of a two-device readback.
// Result queue side: while empty is low the oldest result is on the o_ ports;
// pop takes it. A result is either a cell voltage in millivolts or a frame
// check result (o_last set for the top device frame).
// Configuration: i_cfg_we writes i_cfg_data into the cell count register
// selected by i_cfg_index (0 bottom device, 1 top device), both reset to 12.
// Throughput: one byte per cycle while full is low; the intake updates crc
// and unpack state in the cycle a byte is taken; the scaling stage moves one
// result per cycle, while the result queue is not full, from a two-entry work
// queue to a two-entry result queue; each result passes both queues in turn.
// When the receiver stalls, the result queue fills, then the work queue,
// and full rises; bytes that yield no result still need full low.
// Reset is synchronous and empties both queues and restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_voltage_frame_decoder #(
    parameter int MAX_CELLS_PER_DEVICE = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [3:0]         i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_frame_start,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    o_kind,
    output logic                    o_device_sel,
    output logic [4:0]              o_cell_index,
    output logic signed [13:0]      o_voltage_mv,
    output logic                    o_check_ok,
    output logic                    o_last
);

    localparam int WORK_W = $bits(cvfd_pkg::t_work);
    localparam int RES_W  = $bits(cvfd_pkg::t_result);

    logic              accept;
    logic              work_valid;
    cvfd_pkg::t_work   work_in;
    cvfd_pkg::t_work   work_out;
    logic              work_empty;
    logic              work_take;
    logic              res_full;
    logic              res_push;
    cvfd_pkg::t_result res_in;
    cvfd_pkg::t_result res_out;
    logic [WORK_W-1:0] work_out_bits;
    logic [RES_W-1:0]  res_out_bits;

    assign accept = push && !full;

    cvfd_front #(
        .MAX_CELLS_PER_DEVICE(MAX_CELLS_PER_DEVICE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_work_valid  (work_valid),
        .o_work        (work_in)
    );

    cvfd_fifo #(
        .WIDTH(WORK_W),
        .DEPTH(2)
    ) u_work_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (work_valid),
        .i_wr_data (work_in),
        .o_full    (full),
        .i_rd_en   (work_take),
        .o_rd_data (work_out_bits),
        .o_empty   (work_empty)
    );

    assign work_out = cvfd_pkg::t_work'(work_out_bits);

    cvfd_back u_back (
        .i_work_avail (!work_empty),
        .i_work       (work_out),
        .i_res_full   (res_full),
        .o_work_take  (work_take),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    cvfd_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_push),
        .i_wr_data (res_in),
        .o_full    (res_full),
        .i_rd_en   (pop),
        .o_rd_data (res_out_bits),
        .o_empty   (empty)
    );

    assign res_out      = cvfd_pkg::t_result'(res_out_bits);
    assign o_kind       = res_out.kind;
    assign o_device_sel = res_out.device_sel;
    assign o_cell_index = res_out.cell_index;
    assign o_voltage_mv = res_out.voltage_mv;
    assign o_check_ok   = res_out.check_ok;
    assign o_last       = res_out.last;

endmodule

`default_nettype wire
